// File: design/ptqs_pkg.sv
// ----------------------------------------------------------------------------
// ptqs_pkg
// Shared types and constants of the policy task queue selector.
// ----------------------------------------------------------------------------
package ptqs_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ID_W   = 16;
  localparam int PRIO_W = 2;
  localparam int DL_W   = 32;
  localparam int POL_W  = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [0:0] {
    CMD_ENQ  = 1'b0,
    CMD_TAKE = 1'b1
  } command_t;

  typedef enum logic [POL_W-1:0] {
    POL_FIFO = 2'd0,
    POL_PRIO = 2'd1,
    POL_EDF  = 2'd2,
    POL_RR   = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_GIVEN    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_MOVE = 2'd2,
    S_DONE = 2'd3
  } seq_state_t;

  // one queued task
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [DL_W-1:0]   dl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // one result item
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] prio;
    logic [DL_W-1:0]   dl;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  // store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: design/ptqs_in_if.sv
// ----------------------------------------------------------------------------
// ptqs_in_if
// Command channel: valid/ready handshake with one command item.
// ----------------------------------------------------------------------------
interface ptqs_in_if;
  logic                          valid;
  logic                          ready;
  ptqs_pkg::command_t            command;
  logic [ptqs_pkg::ID_W-1:0]     task_id;
  logic [ptqs_pkg::PRIO_W-1:0]   priority_req;
  logic [ptqs_pkg::DL_W-1:0]     deadline;

  modport source (output valid, command, task_id, priority_req, deadline, input ready);
  modport sink   (input valid, command, task_id, priority_req, deadline, output ready);
endinterface

// File: design/ptqs_out_if.sv
// ----------------------------------------------------------------------------
// ptqs_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface ptqs_out_if;
  logic                          valid;
  logic                          ready;
  ptqs_pkg::status_t             status;
  logic [ptqs_pkg::ID_W-1:0]     out_task_id;
  logic [ptqs_pkg::PRIO_W-1:0]   out_priority;
  logic [ptqs_pkg::DL_W-1:0]     out_deadline;
  logic [ptqs_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_task_id, out_priority, out_deadline, occupancy,
                  input ready);
  modport sink   (input valid, status, out_task_id, out_priority, out_deadline, occupancy,
                  output ready);
endinterface

// File: design/ptqs_ram.sv
// ----------------------------------------------------------------------------
// ptqs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptqs_ram #(
  parameter  int DEPTH = 16,
  parameter  int WIDTH = 50,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/ptqs_seq.sv
// ----------------------------------------------------------------------------
// ptqs_seq
// Command sequencer: appends tasks, scans the store for the policy's pick,
// then closes the gap by moving the later entries down one place.
// ----------------------------------------------------------------------------
module ptqs_seq (
  input  logic                clk,
  input  logic                rst,
  input  ptqs_pkg::policy_t   policy,
  ptqs_in_if.sink             in_ch,
  input  logic                res_take,
  output logic                res_valid,
  output ptqs_pkg::result_t   res,
  output ptqs_pkg::mem_req_t  mem_req,
  input  ptqs_pkg::entry_t    rd_data
);

  localparam int CW = ptqs_pkg::CNT_W;
  localparam int AW = ptqs_pkg::ADDR_W;
  localparam int OW = ptqs_pkg::OCC_W;

  ptqs_pkg::seq_state_t state, state_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        ri;      // next store address to read
  logic [AW-1:0]        di;      // address of the data now on rd_data
  logic                 dv;      // rd_data carries a requested entry
  logic [AW-1:0]        pick, pick_next;
  ptqs_pkg::entry_t     best, best_next;

  logic accept, is_take, is_full, is_empty, issue, reads_done, better;

  assign accept     = in_ch.valid & in_ch.ready;
  assign is_take    = (in_ch.command == ptqs_pkg::CMD_TAKE);
  assign is_full    = (count == CW'(ptqs_pkg::QUEUE_DEPTH));
  assign is_empty   = (count == '0);
  assign reads_done = (ri >= count);
  assign issue      = ((state == ptqs_pkg::S_SCAN) || (state == ptqs_pkg::S_MOVE))
                      && !reads_done;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ptqs_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (is_take && !is_empty) ? ptqs_pkg::S_SCAN : ptqs_pkg::S_DONE;
        end
      end
      ptqs_pkg::S_SCAN: begin
        if (reads_done) begin
          state_next = ptqs_pkg::S_MOVE;
        end
      end
      ptqs_pkg::S_MOVE: begin
        if (reads_done) begin
          state_next = ptqs_pkg::S_DONE;
        end
      end
      ptqs_pkg::S_DONE: begin
        if (res_take) begin
          state_next = ptqs_pkg::S_IDLE;
        end
      end
      default: state_next = ptqs_pkg::S_IDLE;
    endcase
  end

  // outputs and store access; ready is high throughout idle
  always_comb begin
    in_ch.ready     = (state == ptqs_pkg::S_IDLE);
    res_valid       = (state == ptqs_pkg::S_DONE);
    mem_req.we      = 1'b0;
    mem_req.waddr   = count[AW-1:0];
    mem_req.wdata   = rd_data;
    mem_req.raddr   = ri[AW-1:0];
    case (state)
      ptqs_pkg::S_IDLE: begin
        mem_req.raddr      = '0;
        mem_req.wdata.id   = in_ch.task_id;
        mem_req.wdata.prio = in_ch.priority_req;
        mem_req.wdata.dl   = in_ch.deadline;
        mem_req.we         = in_ch.valid && !is_take && !is_full;
      end
      ptqs_pkg::S_MOVE: begin
        mem_req.waddr = di - AW'(1);
        mem_req.we    = dv;
      end
      default: ;
    endcase
  end

  // running choice over the scan; ties keep the earlier entry
  always_comb begin
    case (policy)
      ptqs_pkg::POL_PRIO: better = (rd_data.prio > best.prio);
      ptqs_pkg::POL_EDF:  better = (rd_data.dl < best.dl);
      default:            better = 1'b0;
    endcase
    pick_next = pick;
    best_next = best;
    if (state == ptqs_pkg::S_SCAN && dv && ((di == '0) || better)) begin
      pick_next = di;
      best_next = rd_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptqs_pkg::S_IDLE;
      count <= '0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= issue || (accept && is_take && !is_empty);
      if (accept && !is_take && !is_full) begin
        count <= count + CW'(1);
      end else if (state == ptqs_pkg::S_MOVE && reads_done) begin
        count <= count - CW'(1);
      end
    end
  end

  // read pointers, choice and result
  always_ff @(posedge clk) begin
    pick <= pick_next;
    best <= best_next;
    if (accept) begin
      ri <= CW'(1);
      di <= '0;
    end else if (state == ptqs_pkg::S_SCAN && reads_done) begin
      ri <= CW'(pick_next) + CW'(1);
    end else if (issue) begin
      ri <= ri + CW'(1);
      di <= ri[AW-1:0];
    end

    if (accept) begin
      res.task_id   <= '0;
      res.prio      <= '0;
      res.dl        <= '0;
      res.occupancy <= OW'(count);
      if (is_take) begin
        res.status <= ptqs_pkg::ST_EMPTY;
      end else if (is_full) begin
        res.status <= ptqs_pkg::ST_FULL;
      end else begin
        res.status    <= ptqs_pkg::ST_ENQUEUED;
        res.occupancy <= OW'(count + CW'(1));
      end
    end else if (state == ptqs_pkg::S_MOVE && reads_done) begin
      res.status    <= ptqs_pkg::ST_GIVEN;
      res.task_id   <= best.id;
      res.prio      <= best.prio;
      res.dl        <= best.dl;
      res.occupancy <= OW'(count - CW'(1));
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ptqs_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ptqs_pkg::S_MOVE && mem_req.we) |-> (CW'(mem_req.waddr) < count))
    else $error("compaction write beyond the queued entries");

  a_take_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ptqs_pkg::S_MOVE && reads_done) |=> (count == $past(count) - CW'(1)))
    else $error("take did not remove exactly one entry");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_take && !is_full) |=> (count == $past(count) + CW'(1)))
    else $error("enqueue did not add exactly one entry");

  a_take_pick_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ptqs_pkg::S_SCAN && reads_done) |=> (CW'(pick) < count))
    else $error("chosen entry outside the queue");

endmodule

// File: design/policy_task_queue_selector.sv
// ----------------------------------------------------------------------------
// policy_task_queue_selector
// Ordered task queue with a policy-selected take (fifo, priority, deadline;
// round robin takes like fifo).
//
// Commands arrive on in_ch (valid/ready); each gives exactly one result item
// on out_ch (valid/ready). An enqueue appends the task at the tail or reports
// the queue full; a take removes the chosen task and reports it, or reports
// the queue empty. The remaining tasks keep their order.
// An enqueue and a take on an empty queue are answered from idle without a
// scan. A take on n queued tasks scans the store for the chosen entry p, then
// closes the gap by moving the entries behind p down one place, then hands
// the result over. The scan and the move read the task RAM through its single
// read port, one entry at a time. One command is in flight at a time;
// in_ch.ready is high only while the sequencer is idle. A finished result
// sits in the output register; while out_ch stalls, the next command still
// runs and waits for the register to free. Reset (rst, synchronous) empties
// the queue and sets the policy to fifo. The user must write the policy
// through cfg_we/cfg_data only while no command is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module policy_task_queue_selector (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ptqs_pkg::POL_W-1:0] cfg_data,
  ptqs_in_if.sink                    in_ch,
  ptqs_out_if.source                 out_ch
);

  ptqs_pkg::policy_t  policy;
  ptqs_pkg::result_t  res;
  ptqs_pkg::mem_req_t mem_req;
  logic [ptqs_pkg::ENTRY_W-1:0] rd_raw;
  logic res_valid, res_take;

  // policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= ptqs_pkg::POL_FIFO;
    end else if (cfg_we) begin
      policy <= ptqs_pkg::policy_t'(cfg_data);
    end
  end

  // task store
  ptqs_ram #(
    .DEPTH (ptqs_pkg::QUEUE_DEPTH),
    .WIDTH (ptqs_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rd_raw)
  );

  ptqs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy),
    .in_ch     (in_ch),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (ptqs_pkg::entry_t'(rd_raw))
  );

  // output register
  assign res_take = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_take) begin
      out_ch.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_ch.status       <= res.status;
      out_ch.out_task_id  <= res.task_id;
      out_ch.out_priority <= res.prio;
      out_ch.out_deadline <= res.dl;
      out_ch.occupancy    <= res.occupancy;
    end
  end

endmodule
